// ===== rtl/bce_pkg.sv =====
// Shared types, constants and codes of the button click event engine.
package bce_pkg;

  localparam int NUM_KEYS  = 16;
  localparam int KEY_W     = $clog2(NUM_KEYS);
  localparam int TIME_W    = 32;
  localparam int RAW_W     = 16;
  localparam int BUF_DEPTH = 32;
  localparam int BUF_AW    = $clog2(BUF_DEPTH);
  localparam int CNT_W     = BUF_AW + 1;
  localparam int CFG_IW    = 4;

  typedef enum logic [1:0] {
    EV_PRESS   = 2'd0,
    EV_RELEASE = 2'd1,
    EV_CLICK   = 2'd2,
    EV_KEEP    = 2'd3
  } ev_code_t;

  typedef enum logic [CFG_IW-1:0] {
    CFG_PRESS_DB    = 4'd0,
    CFG_RELEASE_DB  = 4'd1,
    CFG_CLICK_MIN   = 4'd2,
    CFG_CLICK_MAX   = 4'd3,
    CFG_GAP_MAX     = 4'd4,
    CFG_KEEP_PERIOD = 4'd5,
    CFG_MAX_CLICKS  = 4'd6,
    CFG_EVENT_EN    = 4'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [15:0] pressed_keys;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  button_index;
    ev_code_t    event_code;
    logic [7:0]  click_count;
    logic [15:0] keepalive_count;
    logic        any_busy;
    logic        last;
  } out_item_t;

  // One event as stored in the result buffer
  typedef struct packed {
    logic [3:0]  button_index;
    ev_code_t    event_code;
    logic [7:0]  click_count;
    logic [15:0] keepalive_count;
  } ev_t;

  typedef struct packed {
    logic [15:0] press_db;
    logic [15:0] release_db;
    logic [15:0] click_min;
    logic [15:0] click_max;
    logic [15:0] gap_max;
    logic [15:0] keep_period;
    logic [7:0]  max_clicks;
    logic [3:0]  event_en;
  } cfg_t;

  typedef struct packed {
    logic              en;
    logic [BUF_AW-1:0] addr;
    ev_t               ev;
  } buf_wr_t;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] count;
    logic             busy;
  } tick_done_t;

  typedef enum logic [2:0] {
    FE_IDLE,
    FE_LOAD,
    FE_CALC,
    FE_PUT,
    FE_DONE
  } fe_state_t;

  typedef enum logic [1:0] {
    BK_WAIT,
    BK_FETCH,
    BK_SHOW
  } bk_state_t;

endpackage

// ===== rtl/bce_front.sv =====
// Front end: takes a tick, walks the button records and writes events to the buffer.
module bce_front import bce_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       tick_go,
  input  in_item_t   tick_item,
  input  cfg_t       cfg,
  output buf_wr_t    buf_wr,
  output tick_done_t tick_done,
  output logic       idle
);

  fe_state_t state_r, state_nxt;

  logic [KEY_W-1:0]  k_r, k_nxt;
  logic [CNT_W-1:0]  wcnt_r, wcnt_nxt;
  logic [TIME_W-1:0] t_r;
  logic [RAW_W-1:0]  raw_r, was_r, prev_raw_r;
  ev_t               pend_r;

  // Per-button records
  logic [NUM_KEYS-1:0] pr_r, seq_r;
  logic [TIME_W-1:0]   edge_r [NUM_KEYS];
  logic [TIME_W-1:0]   dct_r  [NUM_KEYS];
  logic [TIME_W-1:0]   lct_r  [NUM_KEYS];
  logic [TIME_W-1:0]   kat_r  [NUM_KEYS];
  logic [7:0]          cl_r   [NUM_KEYS];
  logic [15:0]         ka_r   [NUM_KEYS];

  // Elapsed times of the current button, registered in the load step
  logic              now_r, chg_r;
  logic [TIME_W-1:0] d_e_r, d_lc_r, d_kt_r, d_dc_r;
  logic              now_b, chg_b;
  logic [TIME_W-1:0] et_b;

  assign now_b = raw_r[k_r];
  assign chg_b = raw_r[k_r] != was_r[k_r];
  assign et_b  = chg_b ? t_r : edge_r[k_r];

  always_ff @(posedge clk) begin
    if (state_r == FE_LOAD) begin
      now_r  <= now_b;
      chg_r  <= chg_b;
      d_e_r  <= t_r - et_b;
      d_lc_r <= t_r - lct_r[k_r];
      d_kt_r <= t_r - kat_r[k_r];
      d_dc_r <= t_r - dct_r[k_r];
    end
  end

  // Decide the rules of one button
  logic              pr_n, seq_n;
  logic [TIME_W-1:0] et_n, dc_n, lc_n, kt_n;
  logic [7:0]        cl, cl_n, cl_i;
  logic [15:0]       ka, ka_n;
  logic              a_v, b_v, a_en, b_en;
  ev_t               a_ev, b_ev;
  logic              s0_v, s1_v;
  ev_t               s0_ev;

  always_comb begin
    cl    = cl_r[k_r];
    ka    = ka_r[k_r];
    pr_n  = pr_r[k_r];
    seq_n = seq_r[k_r] | (chg_r & now_r);
    et_n  = chg_r ? t_r : edge_r[k_r];
    dc_n  = dct_r[k_r];
    lc_n  = lct_r[k_r];
    kt_n  = kat_r[k_r];
    cl_n  = cl;
    cl_i  = cl;
    ka_n  = ka;
    a_v   = 1'b0;
    b_v   = 1'b0;
    a_ev  = '{button_index: 4'(k_r), event_code: EV_CLICK, click_count: cl,
              keepalive_count: ka};
    b_ev  = a_ev;
    if (now_r) begin
      if (!pr_r[k_r]) begin
        if (d_e_r >= TIME_W'(cfg.press_db)) begin
          kt_n = t_r;
          ka_n = '0;
          pr_n = 1'b1;
          dc_n = t_r;
          if (cl != '0 && d_lc_r >= TIME_W'(cfg.gap_max)) begin
            a_v  = 1'b1;
            cl_n = '0;
            b_v  = 1'b1;
            b_ev.event_code      = EV_PRESS;
            b_ev.click_count     = '0;
            b_ev.keepalive_count = '0;
          end else begin
            a_v = 1'b1;
            a_ev.event_code      = EV_PRESS;
            a_ev.keepalive_count = '0;
          end
        end
      end else begin
        if (cfg.keep_period != '0 && d_kt_r >= TIME_W'(cfg.keep_period)) begin
          kt_n = kat_r[k_r] + TIME_W'(cfg.keep_period);
          ka_n = (ka != 16'hFFFF) ? ka + 16'd1 : ka;
          a_v  = 1'b1;
          a_ev.event_code      = EV_KEEP;
          a_ev.keepalive_count = ka_n;
        end
        if (cl != '0 && d_dc_r > TIME_W'(cfg.click_max)) begin
          cl_n = '0;
          if (a_v) begin
            b_v = 1'b1;
            b_ev.keepalive_count = ka_n;
          end else begin
            a_v = 1'b1;
          end
        end
      end
    end else if (pr_r[k_r]) begin
      if (d_e_r >= TIME_W'(cfg.release_db)) begin
        pr_n = 1'b0;
        dc_n = t_r;
        a_v  = 1'b1;
        a_ev.event_code = EV_RELEASE;
        if (d_dc_r >= TIME_W'(cfg.click_min) && d_dc_r <= TIME_W'(cfg.click_max)) begin
          cl_i = (cl != 8'hFF) ? cl + 8'd1 : cl;
          lc_n = t_r;
        end else begin
          if (cl != '0 && d_dc_r < TIME_W'(cfg.click_min)) begin
            b_v = 1'b1;
          end
          cl_i = '0;
        end
        cl_n = cl_i;
        if (cl_i != '0 && cl_i == cfg.max_clicks) begin
          b_v  = 1'b1;
          b_ev.click_count = cl_i;
          cl_n = '0;
        end
      end
    end else if (cl != '0) begin
      if (d_lc_r >= TIME_W'(cfg.gap_max)) begin
        a_v  = 1'b1;
        cl_n = '0;
      end
    end else begin
      seq_n = 1'b0;
    end
    // Drop disabled events and pack the rest
    a_en  = a_v & cfg.event_en[a_ev.event_code];
    b_en  = b_v & cfg.event_en[b_ev.event_code];
    s0_v  = a_en | b_en;
    s1_v  = a_en & b_en;
    s0_ev = a_en ? a_ev : b_ev;
  end

  // Sequence the walk over the buttons
  logic last_key;
  assign last_key = k_r == KEY_W'(NUM_KEYS - 1);

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    wcnt_nxt  = wcnt_r;
    buf_wr    = '{en: 1'b0, addr: wcnt_r[BUF_AW-1:0], ev: s0_ev};
    unique case (state_r)
      FE_IDLE: begin
        if (tick_go) begin
          k_nxt     = '0;
          wcnt_nxt  = '0;
          state_nxt = FE_LOAD;
        end
      end
      FE_LOAD: state_nxt = FE_CALC;
      FE_CALC: begin
        if (s0_v && wcnt_r < CNT_W'(BUF_DEPTH)) begin
          buf_wr.en = 1'b1;
          wcnt_nxt  = wcnt_r + 1'b1;
        end
        if (s1_v) begin
          state_nxt = FE_PUT;
        end else if (last_key) begin
          state_nxt = FE_DONE;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = FE_LOAD;
        end
      end
      FE_PUT: begin
        buf_wr.ev = pend_r;
        if (wcnt_r < CNT_W'(BUF_DEPTH)) begin
          buf_wr.en = 1'b1;
          wcnt_nxt  = wcnt_r + 1'b1;
        end
        if (last_key) begin
          state_nxt = FE_DONE;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = FE_LOAD;
        end
      end
      FE_DONE: state_nxt = FE_IDLE;
      default: state_nxt = FE_IDLE;
    endcase
  end

  assign tick_done = '{done: state_r == FE_DONE, count: wcnt_r, busy: |seq_r};
  assign idle      = state_r == FE_IDLE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FE_IDLE;
      k_r     <= '0;
      wcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      wcnt_r  <= wcnt_nxt;
    end
  end

  // Capture the tick and hold the second event of a button
  always_ff @(posedge clk) begin
    if (state_r == FE_IDLE && tick_go) begin
      t_r   <= tick_item.now_ms[TIME_W-1:0];
      raw_r <= tick_item.pressed_keys;
    end
    if (state_r == FE_CALC) begin
      pend_r <= b_ev;
    end
  end

  // Update the button records
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_raw_r <= '0;
      was_r      <= '0;
      pr_r       <= '0;
      seq_r      <= '0;
      for (int i = 0; i < NUM_KEYS; i++) begin
        edge_r[i] <= '0;
        dct_r[i]  <= '0;
        lct_r[i]  <= '0;
        kat_r[i]  <= '0;
        cl_r[i]   <= '0;
        ka_r[i]   <= '0;
      end
    end else begin
      if (state_r == FE_IDLE && tick_go) begin
        was_r      <= prev_raw_r;
        prev_raw_r <= tick_item.pressed_keys;
      end
      if (state_r == FE_CALC) begin
        pr_r[k_r]   <= pr_n;
        seq_r[k_r]  <= seq_n;
        edge_r[k_r] <= et_n;
        dct_r[k_r]  <= dc_n;
        lct_r[k_r]  <= lc_n;
        kat_r[k_r]  <= kt_n;
        cl_r[k_r]   <= cl_n;
        ka_r[k_r]   <= ka_n;
      end
    end
  end

  a_wr_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    buf_wr.en |-> (state_r == FE_CALC || state_r == FE_PUT))
    else $error("buffer write outside the button walk");
  a_put_after_calc: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == FE_PUT |-> $past(state_r) == FE_CALC)
    else $error("second event slot without a decision step");
  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == FE_DONE |=> state_r == FE_IDLE)
    else $error("front did not return to idle after the tick");

endmodule

// ===== rtl/bce_back.sv =====
// Back end: holds the events of a tick and hands them out with busy and last marks.
module bce_back import bce_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  buf_wr_t    buf_wr,
  input  tick_done_t tick_done,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data,
  output logic       idle
);

  bk_state_t state_r, state_nxt;

  ev_t              mem [BUF_DEPTH];
  ev_t              rd_data_r;
  logic [BUF_AW-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0]  n_r;
  logic              busy_r;
  logic              is_last;

  // Event buffer: one write, one registered read
  always_ff @(posedge clk) begin
    if (buf_wr.en) begin
      mem[buf_wr.addr] <= buf_wr.ev;
    end
    rd_data_r <= mem[idx_r];
  end

  assign is_last = CNT_W'(idx_r) + 1'b1 == n_r;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      BK_WAIT: begin
        if (tick_done.done && tick_done.count != '0) begin
          idx_nxt   = '0;
          state_nxt = BK_FETCH;
        end
      end
      BK_FETCH: state_nxt = BK_SHOW;
      BK_SHOW: begin
        if (!out_stall) begin
          if (is_last) begin
            state_nxt = BK_WAIT;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = BK_FETCH;
          end
        end
      end
      default: state_nxt = BK_WAIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_WAIT;
      idx_r   <= '0;
      n_r     <= '0;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      if (state_r == BK_WAIT && tick_done.done) begin
        n_r    <= tick_done.count;
        busy_r <= tick_done.busy;
      end
    end
  end

  assign out_valid = state_r == BK_SHOW;
  assign out_data  = '{button_index: rd_data_r.button_index,
                       event_code: rd_data_r.event_code,
                       click_count: rd_data_r.click_count,
                       keepalive_count: rd_data_r.keepalive_count,
                       any_busy: busy_r,
                       last: is_last};
  assign idle      = state_r == BK_WAIT;

  a_done_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    tick_done.done |-> state_r == BK_WAIT)
    else $error("tick finished while the buffer was still draining");
  a_count_fits: assert property (@(posedge clk) disable iff (!rst_n)
    tick_done.done |-> tick_done.count <= CNT_W'(BUF_DEPTH))
    else $error("event count exceeds the buffer");
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BK_SHOW && is_last && !out_stall) |=> state_r == BK_WAIT)
    else $error("back end kept draining after the last item");

endmodule

// ===== rtl/button_click_event_engine_unit.sv =====
// Top level of the button click event engine: configuration registers and wiring.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | in_item_t (now_ms, pressed_keys)
//   out_    | output    | out_valid/out_stall| out_item_t (event fields, any_busy, last)
//   cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A tick walks the sixteen buttons through the single shared rule unit: a load
// step and a decision step per button, plus a put step for a second event, then
// a done step closes the tick. Its events then leave one by one through the
// buffer's registered read port, each fetched and then shown until taken. in_stall
// stays high from acceptance until the last item of the tick is taken. Synchronous
// reset clears all button records and restores register defaults.
module button_click_event_engine_unit import bce_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [31:0]       cfg_data
);

  cfg_t       cfg_r;
  buf_wr_t    buf_wr;
  tick_done_t tick_done;
  logic       fe_idle, bk_idle, tick_go;

  assign cfg_ready = 1'b1;
  assign in_stall  = !(fe_idle && bk_idle);
  assign tick_go   = in_valid && !in_stall;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{press_db: 16'd20, release_db: 16'd0, click_min: 16'd20,
                 click_max: 16'd300, gap_max: 16'd200, keep_period: 16'd500,
                 max_clicks: 8'd3, event_en: 4'hF};
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PRESS_DB:    cfg_r.press_db    <= cfg_data[15:0];
        CFG_RELEASE_DB:  cfg_r.release_db  <= cfg_data[15:0];
        CFG_CLICK_MIN:   cfg_r.click_min   <= cfg_data[15:0];
        CFG_CLICK_MAX:   cfg_r.click_max   <= cfg_data[15:0];
        CFG_GAP_MAX:     cfg_r.gap_max     <= cfg_data[15:0];
        CFG_KEEP_PERIOD: cfg_r.keep_period <= cfg_data[15:0];
        CFG_MAX_CLICKS:  cfg_r.max_clicks  <= cfg_data[7:0];
        CFG_EVENT_EN:    cfg_r.event_en    <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  bce_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .tick_go   (tick_go),
    .tick_item (in_data),
    .cfg       (cfg_r),
    .buf_wr    (buf_wr),
    .tick_done (tick_done),
    .idle      (fe_idle)
  );

  bce_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .buf_wr    (buf_wr),
    .tick_done (tick_done),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .idle      (bk_idle)
  );

endmodule
